@@ src/scmf_pkg.sv @@
// Shared types and constants for the checksum message framer.
// Holds the job record passed from the front end to the back end.
// No dependencies.
package scmf_pkg;

  // Protocol selector codes
  localparam logic [1:0] PROTO_MCU    = 2'd0;
  localparam logic [1:0] PROTO_SECOND = 2'd1;
  localparam logic [1:0] PROTO_GUI    = 2'd2;
  localparam logic [1:0] PROTO_NONE   = 2'd3;

  // Sync byte pairs
  localparam logic [7:0] SYNC_MCU_1    = 8'hff;
  localparam logic [7:0] SYNC_MCU_2    = 8'h55;
  localparam logic [7:0] SYNC_SECOND_1 = 8'haa;
  localparam logic [7:0] SYNC_SECOND_2 = 8'h33;
  localparam logic [7:0] SYNC_GUI_1    = 8'hbb;
  localparam logic [7:0] SYNC_GUI_2    = 8'h44;

  // Input command codes
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Header layout in the job byte slots
  localparam int HDR_BYTES = 7;
  localparam int SLOT_W    = 3;
  localparam logic [SLOT_W-1:0] SLOT_LEN      = SLOT_W'(HDR_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_HDR_SUM  = SLOT_W'(HDR_BYTES);
  localparam logic [SLOT_W-1:0] SLOT_PAY_SUM  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST    = SLOT_W'(0);

  // Job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    JOB_HDR = 2'd0,
    JOB_PAY = 2'd1,
    JOB_MIS = 2'd2
  } job_kind_t;

  // One classified item: header bytes in slots 0..6, payload byte in slot 0
  typedef struct packed {
    job_kind_t             kind;
    logic [7:0][7:0]       bytes;
    logic                  close;
  } job_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

@@ src/scmf_front.sv @@
// Front end of the framer: accepts input beats and tracks frame state.
// Queues a job per beat, none for a PROTO_NONE header. Uses scmf_pkg.
module scmf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,
  input  logic             s_tuser,
  input  logic             q_full,
  output logic             push,
  output scmf_pkg::job_t   push_job
);

  logic       frame_open;
  logic [7:0] bytes_left;
  logic       accept;

  logic [1:0] protocol;
  logic [7:0] src_addr;
  logic [7:0] dest_addr;
  logic [7:0] msg_type;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;
  logic [7:0] sync1;
  logic [7:0] sync2;
  logic [7:0] type_byte;

  // Unpack the beat
  assign protocol       = s_tdata[1:0];
  assign src_addr       = s_tdata[9:2];
  assign dest_addr      = s_tdata[17:10];
  assign msg_type       = s_tdata[25:18];
  assign command_code   = s_tdata[33:26];
  assign payload_length = s_tdata[41:34];
  assign payload_byte   = s_tdata[49:42];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Resolve sync bytes and type byte from the protocol
  always_comb begin
    sync1     = scmf_pkg::SYNC_GUI_1;
    sync2     = scmf_pkg::SYNC_GUI_2;
    type_byte = msg_type;
    unique case (protocol)
      scmf_pkg::PROTO_MCU: begin
        sync1 = scmf_pkg::SYNC_MCU_1;
        sync2 = scmf_pkg::SYNC_MCU_2;
      end
      scmf_pkg::PROTO_SECOND: begin
        sync1 = scmf_pkg::SYNC_SECOND_1;
        sync2 = scmf_pkg::SYNC_SECOND_2;
      end
      default: begin
        type_byte = 8'h00;
      end
    endcase
  end

  // Build the job for this beat
  always_comb begin
    push_job       = '0;
    push_job.kind  = scmf_pkg::JOB_MIS;
    push           = 1'b0;
    if (s_tuser == scmf_pkg::CMD_HEADER) begin
      push_job.kind  = scmf_pkg::JOB_HDR;
      push_job.bytes = {8'h00, payload_length, command_code, type_byte,
                        dest_addr, src_addr, sync2, sync1};
      push_job.close = (payload_length == 8'h00);
      push           = accept && (protocol != scmf_pkg::PROTO_NONE);
    end else if (frame_open) begin
      push_job.kind     = scmf_pkg::JOB_PAY;
      push_job.bytes[0] = payload_byte;
      push_job.close    = (bytes_left == 8'd1);
      push              = accept;
    end else begin
      push = accept;
    end
  end

  // Track the open frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 8'h00;
    end else if (accept) begin
      if (s_tuser == scmf_pkg::CMD_HEADER) begin
        frame_open <= (protocol != scmf_pkg::PROTO_NONE) && (payload_length != 8'h00);
        bytes_left <= (protocol != scmf_pkg::PROTO_NONE) ? payload_length : 8'h00;
      end else if (frame_open) begin
        bytes_left <= bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/scmf_queue.sv @@
// Short job queue between the front and back ends of the framer.
// Register based FIFO of scmf_pkg::job_t, depth scmf_pkg::QDEPTH.
module scmf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  scmf_pkg::job_t        push_job,
  input  logic                  pop,
  output scmf_pkg::job_t        head,
  output scmf_pkg::q_status_t   status
);

  scmf_pkg::job_t                   slots [scmf_pkg::QDEPTH];
  logic [scmf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [scmf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [scmf_pkg::QCNT_W-1:0]      count;

  localparam logic [scmf_pkg::QPTR_W-1:0] PTR_LAST = scmf_pkg::QPTR_W'(scmf_pkg::QDEPTH - 1);
  localparam logic [scmf_pkg::QCNT_W-1:0] CNT_FULL = scmf_pkg::QCNT_W'(scmf_pkg::QDEPTH);

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_FULL);
  assign status.valid = (count != '0);

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/scmf_back.sv @@
// Back end of the framer: expands jobs into output beats.
// Keeps the running byte sum and the output register. Uses scmf_pkg.
module scmf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  scmf_pkg::job_t      job,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  logic [scmf_pkg::SLOT_W-1:0] slot;
  logic [7:0]                  running_sum;
  logic [7:0]                  running_sum_next;
  logic [7:0]                  cur_byte;
  logic                        cur_end;
  logic                        cur_mis;
  logic                        last;
  logic                        advance;

  assign advance = q_valid && (!m_tvalid || m_tready);
  assign pop     = advance && last;

  // Select the byte for the current slot of the job
  always_comb begin
    cur_byte = 8'h00;
    cur_end  = 1'b0;
    cur_mis  = 1'b0;
    last     = 1'b1;
    unique case (job.kind)
      scmf_pkg::JOB_HDR: begin
        if (slot == scmf_pkg::SLOT_HDR_SUM) begin
          cur_byte = running_sum;
          cur_end  = 1'b1;
        end else begin
          cur_byte = job.bytes[slot];
          last     = (slot == scmf_pkg::SLOT_LEN) && !job.close;
        end
      end
      scmf_pkg::JOB_PAY: begin
        if (slot == scmf_pkg::SLOT_PAY_SUM) begin
          cur_byte = running_sum;
          cur_end  = 1'b1;
        end else begin
          cur_byte = job.bytes[0];
          last     = !job.close;
        end
      end
      default: begin
        cur_mis = 1'b1;
      end
    endcase
  end

  // Fold the emitted byte into the sum; a header restarts it
  always_comb begin
    priority if (cur_end) begin
      running_sum_next = 8'h00;
    end else if (cur_mis) begin
      running_sum_next = running_sum;
    end else if (job.kind == scmf_pkg::JOB_HDR && slot == scmf_pkg::SLOT_FIRST) begin
      running_sum_next = cur_byte;
    end else begin
      running_sum_next = running_sum + cur_byte;
    end
  end

  // Step through slots and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= scmf_pkg::SLOT_FIRST;
      running_sum <= 8'h00;
    end else if (advance) begin
      slot        <= last ? scmf_pkg::SLOT_FIRST : slot + 1'b1;
      running_sum <= running_sum_next;
    end
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= cur_byte;
      m_tlast <= cur_end;
      m_tuser <= cur_mis;
    end
  end

endmodule

@@ src/sum_checksum_message_framer.sv @@
// Top level of the byte sum checksum message framer.
// Ties scmf_front, scmf_queue and scmf_back together. Uses scmf_pkg.
//
//  channel | dir | handshake           | content
//  s_      | in  | s_tvalid / s_tready | header or payload item, cmd on s_tuser
//  m_      | out | m_tvalid / m_tready | frame byte, checksum on m_tlast
//
// An input beat is taken whenever the two-entry job queue has
// room; a header yields 7 output beats (8 with an empty payload), a payload
// item 1 (2 when it closes the frame), a misplaced payload item 1.
// The output register moves one beat per cycle while m_tready is high, so
// payload streams at one item per cycle and header bursts drain at the output rate.
// Reset is synchronous and clears frame state, the queue and m_tvalid.
// A stall on m_tready holds the output beat and fills the queue, which then
// drops s_tready.
module sum_checksum_message_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // protocol[1:0], src_addr[9:2], dest_addr[17:10],
                                 // msg_type[25:18], command_code[33:26],
                                 // payload_length[41:34], payload_byte[49:42], zero
  input  logic        s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic        m_tuser    // misuse[0]
);

  logic                  push;
  logic                  pop;
  scmf_pkg::job_t        push_job;
  scmf_pkg::job_t        head;
  scmf_pkg::q_status_t   q_status;

  scmf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_status.full),
    .push     (push),
    .push_job (push_job)
  );

  scmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  scmf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_status.valid),
    .job      (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // A misuse beat never closes a frame
  a_mis_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast)
    else $error("misuse beat marked as frame end");

  // A misuse beat carries a zero byte
  a_mis_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'h00)
    else $error("misuse beat carries data");

  // The back end only retires jobs that are present
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.valid)
    else $error("job popped from empty queue");

  // Nothing enters a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

endmodule
